// File: rtl/msm_pkg.sv
// Shared constants, request/result codes and the queued word type of the stream matcher.
package msm_pkg;
  localparam int NUM_SLOTS   = 16;
  localparam int MAX_LEN     = 32;
  localparam int SYMBOL_BITS = 21;

  localparam int SLOT_W  = 4;                        // fixed by the slot field
  localparam int POS_W   = 5;                        // fixed by the position field
  localparam int LEN_W   = 6;                        // fixed by the length field
  localparam int CNT_W   = 5;
  localparam int DEPTH   = NUM_SLOTS * MAX_LEN;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int GRP_W   = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    REQ_STREAM = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_ENABLE = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_MATCH   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_TABLE   = 2'd2
  } kind_e;

  typedef struct packed {
    req_e                   req;
    logic [SYMBOL_BITS-1:0] sym;
    logic [SLOT_W-1:0]      slot;
    logic [POS_W-1:0]       pos;
    logic [LEN_W-1:0]       len;    // already saturated to MAX_LEN
  } item_t;
endpackage

// File: rtl/msm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// File: rtl/msm_front.sv
// Front end: accepts request words, decodes them and queues them for the back end.
module msm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [1:0]    req_type_i,
  input  logic [msm_pkg::SYMBOL_BITS-1:0] symbol_i,
  input  logic [3:0]    slot_i,
  input  logic [4:0]    position_i,
  input  logic [5:0]    pattern_length_i,
  output logic          valid_o,
  output msm_pkg::item_t item_o,
  input  logic          pop_i
);
  import msm_pkg::*;

  item_t      fifo_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  item_t      dec;
  logic       push;

  always_comb begin
    dec.req  = req_e'(req_type_i);
    dec.sym  = symbol_i;
    dec.slot = slot_i;
    dec.pos  = position_i;
    dec.len  = (pattern_length_i > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : pattern_length_i;
  end

  assign busy_o  = (cnt_q == 2'd2);
  assign push    = start_i && !busy_o;
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = fifo_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= dec;
    end
  end
endmodule

// File: rtl/msm_back.sv
// Back end: slot table, shift-and match state, pattern RAM sweep and result sequencing.
module msm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  msm_pkg::item_t item_i,
  output logic           pop_o,
  output logic           res_valid_o,
  output logic [1:0]     kind_o,
  output logic [3:0]     matched_slot_o,
  output logic [4:0]     match_count_o,
  output logic           slot_was_set_o,
  output logic           last_o
);
  import msm_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_EMIT, ST_SUM, ST_TBL} state_e;

  state_e                    state_q;
  item_t                     item_q;
  logic [NUM_SLOTS-1:0]      enabled_q;
  logic [LEN_W-1:0]          len_q [NUM_SLOTS];
  logic [MAX_LEN-1:0]        dvec_q [NUM_SLOTS];   // prefix-match bits per slot
  logic [MAX_LEN-1:0]        dnew_q;
  logic [NUM_SLOTS-1:0]      hit_q, emitted_q;
  logic [SLOT_W-1:0]         s_q;
  logic [POS_W-1:0]          j_q;
  logic                      ph_q;
  logic [GRP_W-1:0]          g_q;
  logic [CNT_W-1:0]          count_q;

  logic [SYMBOL_BITS-1:0]    rdata;
  logic                      ram_we, ram_re;
  logic                      active, last_pos, bit_new, prev_ok;
  logic [LEN_W-1:0]          want;
  logic [NUM_SLOTS-1:0]      mask;
  logic                      found;
  logic [SLOT_W-1:0]         pick;

  assign pop_o  = (state_q == ST_IDLE) && valid_i;
  assign ram_we = (state_q == ST_TBL) && (item_q.req == REQ_WRITE);
  assign active = enabled_q[s_q] && (len_q[s_q] != '0);
  assign ram_re = (state_q == ST_SCAN) && active && !ph_q;

  msm_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(DEPTH)) u_pat (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({item_q.slot, item_q.pos}),
    .wdata_i (item_q.sym),
    .re_i    (ram_re),
    .raddr_i ({s_q, j_q}),
    .rdata_o (rdata)
  );

  always_comb begin
    prev_ok  = (j_q == '0) || dvec_q[s_q][j_q - POS_W'(1)];
    bit_new  = prev_ok && (rdata == item_q.sym);
    last_pos = ({1'b0, j_q} == (len_q[s_q] - LEN_W'(1)));
  end

  // group order: zero-length slots, lengths 2..MAX_LEN, then length 1
  always_comb begin
    if (g_q == '0) begin
      want = '0;
    end else if (g_q == GRP_W'(MAX_LEN)) begin
      want = LEN_W'(1);
    end else begin
      want = LEN_W'(g_q) + LEN_W'(1);
    end
    found = 1'b0;
    pick  = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      mask[s] = enabled_q[s] && (len_q[s] == want) && ((want == '0) || hit_q[s])
                && !emitted_q[s];
      if (mask[s]) begin
        found = 1'b1;
        pick  = SLOT_W'(s);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      enabled_q      <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        len_q[s]  <= '0;
        dvec_q[s] <= '0;
      end
      dnew_q         <= '0;
      res_valid_o    <= 1'b0;
      kind_o         <= KIND_MATCH;
      matched_slot_o <= '0;
      match_count_o  <= '0;
      slot_was_set_o <= 1'b0;
      last_o         <= 1'b0;
      s_q            <= '0;
      j_q            <= '0;
      ph_q           <= 1'b0;
      g_q            <= '0;
      count_q        <= '0;
      hit_q          <= '0;
      emitted_q      <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          res_valid_o <= 1'b0;
          if (valid_i) begin
            s_q   <= '0;
            j_q   <= '0;
            ph_q  <= 1'b0;
            hit_q <= '0;
            state_q <= (item_i.req == REQ_STREAM) ? ST_SCAN : ST_TBL;
          end
        end
        ST_SCAN: begin
          res_valid_o <= 1'b0;
          if (active && !ph_q) begin
            ph_q <= 1'b1;
            if (j_q == '0) begin
              dnew_q <= '0;
            end
          end else begin
            if (active) begin
              ph_q <= 1'b0;
              dnew_q[j_q] <= bit_new;
            end
            if (!active || last_pos) begin
              if (active) begin
                dvec_q[s_q] <= dnew_q | (MAX_LEN'(bit_new) << j_q);
                hit_q[s_q]  <= bit_new;
              end
              j_q <= '0;
              s_q <= s_q + SLOT_W'(1);
              if (s_q == SLOT_W'(NUM_SLOTS - 1)) begin
                g_q       <= '0;
                emitted_q <= '0;
                count_q   <= '0;
                state_q   <= ST_EMIT;
              end
            end else begin
              j_q <= j_q + POS_W'(1);
            end
          end
        end
        ST_EMIT: begin
          if (found) begin
            emitted_q[pick] <= 1'b1;
            count_q         <= count_q + CNT_W'(1);
            res_valid_o     <= 1'b1;
            kind_o          <= KIND_MATCH;
            matched_slot_o  <= pick;
            match_count_o   <= '0;
            slot_was_set_o  <= 1'b0;
            last_o          <= 1'b0;
          end else begin
            res_valid_o <= 1'b0;
            emitted_q   <= '0;
            g_q         <= g_q + GRP_W'(1);
            if (g_q == GRP_W'(MAX_LEN)) begin
              state_q <= ST_SUM;
            end
          end
        end
        ST_SUM: begin
          res_valid_o    <= 1'b1;
          kind_o         <= KIND_SUMMARY;
          matched_slot_o <= '0;
          match_count_o  <= count_q;
          slot_was_set_o <= 1'b0;
          last_o         <= 1'b1;
          state_q        <= ST_IDLE;
        end
        ST_TBL: begin
          slot_was_set_o <= (item_q.req == REQ_REMOVE) && enabled_q[item_q.slot];
          case (item_q.req)
            REQ_ENABLE: begin
              enabled_q[item_q.slot] <= 1'b1;
              len_q[item_q.slot]     <= item_q.len;
            end
            REQ_REMOVE: begin
              enabled_q[item_q.slot] <= 1'b0;
            end
            default: ;
          endcase
          for (int s = 0; s < NUM_SLOTS; s++) begin
            dvec_q[s] <= '0;
          end
          res_valid_o    <= 1'b1;
          kind_o         <= KIND_TABLE;
          matched_slot_o <= '0;
          match_count_o  <= '0;
          last_o         <= 1'b1;
          state_q        <= ST_IDLE;
        end
        default: begin
          res_valid_o <= 1'b0;
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
  end
endmodule

// File: rtl/multi_pattern_stream_matcher.sv
// Top level of the multi-pattern stream matcher: request queue plus execution engine.
//
// Usage: drive a request word (req_type_i and its fields) with start high;
// it is taken at a clock edge where busy is low. A two-word queue sits
// between the decoder and the engine, so up to two words may be taken while
// the engine still works on an earlier one.
// Results: valid_o marks each result word for exactly one cycle; the receiver
// cannot stall, so every word must be captured when valid_o is high.
// last_o flags the final word a request causes.
// Table requests (write, enable, remove) answer one word. A stream symbol
// sweeps the pattern RAM, reading each pattern symbol of every enabled slot
// with nonzero length and skipping other slots, then steps through MAX_LEN+1
// length groups, giving a match word for each hit or enabled zero-length slot,
// then the summary word. The pattern RAM has a single read port.
// Matching uses per-slot shift-and prefix bits, which any table request clears
// (this is the symbol history clear).
// Reset (rst_ni low, asynchronous) disables all slots, zeroes lengths and
// history and empties the queue; pattern RAM contents stay undefined until
// written.
module multi_pattern_stream_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [msm_pkg::SYMBOL_BITS-1:0] symbol_i,
  input  logic [3:0]  slot_i,
  input  logic [4:0]  position_i,
  input  logic [5:0]  pattern_length_i,
  output logic        valid_o,
  output logic [1:0]  kind_o,
  output logic [3:0]  matched_slot_o,
  output logic [4:0]  match_count_o,
  output logic        slot_was_set_o,
  output logic        last_o
);
  import msm_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  msm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_o           (busy),
    .req_type_i       (req_type_i),
    .symbol_i         (symbol_i),
    .slot_i           (slot_i),
    .position_i       (position_i),
    .pattern_length_i (pattern_length_i),
    .valid_o          (q_valid),
    .item_o           (q_item),
    .pop_i            (q_pop)
  );

  msm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (q_item),
    .pop_o          (q_pop),
    .res_valid_o    (valid_o),
    .kind_o         (kind_o),
    .matched_slot_o (matched_slot_o),
    .match_count_o  (match_count_o),
    .slot_was_set_o (slot_was_set_o),
    .last_o         (last_o)
  );
endmodule
